### design/imconv3_pkg.sv
// ----------------------------------------------------------------------------
// imconv3_pkg
// Shared constants, types and register codes of the 3x3 convolution block.
// ----------------------------------------------------------------------------
package imconv3_pkg;

   // Geometry
   localparam int MAX_WIDTH = 1024;
   localparam int LANES     = 4;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 16;
   localparam int ROW_W     = HEIGHT_W + 1;
   localparam int LANES_W   = 3;

   // Arithmetic
   localparam int COEF_W    = 16;
   localparam int ROWREG_W  = 3 * COEF_W;
   localparam int PROD_W    = 25;
   localparam int SUM_W     = 28;
   localparam int FRAC_W    = 8;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;

   // Register port
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   typedef enum logic [2:0] {
      CSR_COEF_TOP    = 3'd0,
      CSR_COEF_MIDDLE = 3'd1,
      CSR_COEF_BOTTOM = 3'd2,
      CSR_WIDTH       = 3'd3,
      CSR_HEIGHT      = 3'd4,
      CSR_LANES       = 3'd5
   } csr_index_type;

   typedef logic [LANES-1:0][7:0]            pixel_type;
   typedef pixel_type [2:0]                  column_type;   // 0 = top row
   typedef logic [2:0][COEF_W-1:0]           coef_col_type;
   typedef logic [LANES-1:0][SUM_W-1:0]      colsum_type;

   typedef struct packed {
      logic shift;
      logic kill_top;
      logic kill_bot;
      logic kill_col;
   } cell_ctrl_type;

   typedef struct packed {
      pixel_type data;
      logic      frame_end;
   } rsp_item_type;

endpackage

### design/imconv3_line_buf.sv
// ----------------------------------------------------------------------------
// imconv3_line_buf
// Two line stores: the previous row and the row before it, one entry per
// column. The older store is refilled in the cycle after the read, with a
// bypass for back-to-back hits on the same column.
// ----------------------------------------------------------------------------
module imconv3_line_buf (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [imconv3_pkg::COL_W-1:0]  addr,
   input  imconv3_pkg::pixel_type         wr_pixel,
   output imconv3_pkg::pixel_type         up1,
   output imconv3_pkg::pixel_type         up2
);
   import imconv3_pkg::*;

   pixel_type            mem_a [MAX_WIDTH];
   pixel_type            mem_b [MAX_WIDTH];
   pixel_type            a_rd_ff;
   pixel_type            b_rd_ff;
   pixel_type            fwd_data_ff;
   logic                 fwd_ff;
   logic                 pend_ff;
   logic [COL_W-1:0]     pend_addr_ff;

   // Previous row: read old value, store the new pixel
   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_rd_ff     <= mem_a[addr];
         mem_a[addr] <= wr_pixel;
      end
   end

   // Older row: take the previous-row value in the following cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         b_rd_ff     <= mem_b[addr];
         fwd_data_ff <= a_rd_ff;
      end
      if (pend_ff) begin
         mem_b[pend_addr_ff] <= a_rd_ff;
      end
   end

   // Track the pending write and bypass a same-column read
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         pend_ff <= rd_en;
         if (rd_en) begin
            fwd_ff <= pend_ff && (pend_addr_ff == addr);
         end
      end
      if (rd_en) begin
         pend_addr_ff <= addr;
      end
   end

   assign up1 = a_rd_ff;
   assign up2 = fwd_ff ? fwd_data_ff : b_rd_ff;

endmodule

### design/imconv3_cell.sv
// ----------------------------------------------------------------------------
// imconv3_cell
// One window column: holds three taps, passes them to its left neighbor on
// each shift, multiplies them by its coefficient column and sums per lane.
// ----------------------------------------------------------------------------
module imconv3_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  imconv3_pkg::cell_ctrl_type  ctrl,
   input  imconv3_pkg::column_type     col_in,
   input  imconv3_pkg::coef_col_type   coef,
   output imconv3_pkg::column_type     col_out,
   output imconv3_pkg::colsum_type     colsum
);
   import imconv3_pkg::*;

   column_type                 col_ff;
   logic signed [PROD_W-1:0]   prod_ff [3][LANES];
   logic signed [PROD_W-1:0]   prod_in [3][LANES];
   colsum_type                 colsum_ff;
   colsum_type                 colsum_in;
   logic [2:0]                 kill;

   // Hold the taps, advance on shift
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (ctrl.shift) begin
         col_ff <= col_in;
      end
   end

   // Drop taps outside the frame
   assign kill[0] = ctrl.kill_top | ctrl.kill_col;
   assign kill[1] = ctrl.kill_col;
   assign kill[2] = ctrl.kill_bot | ctrl.kill_col;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < LANES; k++) begin
            if (kill[r]) begin
               prod_in[r][k] = '0;
            end else begin
               prod_in[r][k] = $signed(coef[r]) * $signed({1'b0, col_ff[r][k]});
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         colsum_in[k] = SUM_W'(prod_ff[0][k]) + SUM_W'(prod_ff[1][k])
                      + SUM_W'(prod_ff[2][k]);
      end
   end

   // Register products, then column sums
   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      colsum_ff <= colsum_in;
   end

   assign col_out = col_ff;
   assign colsum  = colsum_ff;

endmodule

### design/image_convolution_3x3.sv
// ----------------------------------------------------------------------------
// image_convolution_3x3
// Streaming 3x3 zero-padded convolution over up to four 8-bit lanes, built
// as a row of three window-column cells fed by two line stores.
// ----------------------------------------------------------------------------
// Throughput: one beat per clock on each side while rsp_ready is held high.
// A result leaves after the beat that completes its window has passed the
//   line store read, window shift, products, column sums and queue write.
// An 8-entry result queue decouples the two sides; req_ready follows its credit.
// Reset: clears position, window, queue and restores register defaults; the
//   line stores are not cleared (their stale entries only reach padded taps).
// ----------------------------------------------------------------------------
module image_convolution_3x3 (
   input  logic                            clock,
   input  logic                            reset,
   // input beats
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [7:0]                      req_sample_ch0,
   input  logic [7:0]                      req_sample_ch1,
   input  logic [7:0]                      req_sample_ch2,
   input  logic [7:0]                      req_sample_ch3,
   // result beats
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_filtered_ch0,
   output logic [7:0]                      rsp_filtered_ch1,
   output logic [7:0]                      rsp_filtered_ch2,
   output logic [7:0]                      rsp_filtered_ch3,
   output logic                            rsp_frame_end,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [imconv3_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [imconv3_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [imconv3_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import imconv3_pkg::*;

   // Registers
   logic [ROWREG_W-1:0]  coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [WIDTH_W-1:0]   width_ff;
   logic [HEIGHT_W-1:0]  height_ff;
   logic [LANES_W-1:0]   lanes_ff;
   logic                 csr_wr;
   csr_index_type        csr_index;

   // Position
   logic [COL_W-1:0]     in_column_ff, in_column_in;
   logic [ROW_W-1:0]     in_row_ff, in_row_in;

   // Position decode
   logic [WIDTH_W-1:0]   w_eff;
   logic [HEIGHT_W-1:0]  h_eff;
   logic [LANES_W-1:0]   lanes_eff;
   logic [COL_W-1:0]     w_last;
   logic                 wrap_pre, wrap_post, drain, accept, process;
   logic [COL_W-1:0]     col_pre, col_post, ccol;
   logic [ROW_W-1:0]     row_pre, row_post, crow;
   logic [WIDTH_W-1:0]   col_inc;
   logic                 col_nz, win_valid, emit, last;
   logic                 pad_top, pad_bot, pad_left, pad_right;
   pixel_type            pixel;
   pixel_type            samples;

   // Pipeline
   logic                 p1_valid_ff, p1_emit_ff, p1_last_ff;
   logic                 p1_top_ff, p1_bot_ff, p1_left_ff, p1_right_ff;
   pixel_type            p1_pixel_ff;
   logic                 p2_emit_ff, p2_last_ff;
   logic                 p2_top_ff, p2_bot_ff, p2_left_ff, p2_right_ff;
   logic                 p3_emit_ff, p3_last_ff;
   logic                 p4_emit_ff, p4_last_ff;

   pixel_type            up1, up2;
   cell_ctrl_type        ctrl [3];
   column_type           col_link [4];
   colsum_type           colsum [3];
   coef_col_type         coef [3];

   // Result queue
   rsp_item_type         fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff;
   logic [FIFO_CW:0]     inflight;
   logic                 push, pop;
   rsp_item_type         result;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_AW-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= '0;
         coef_mid_ff <= ROWREG_W'(48'h0000_0100_0000);
         coef_bot_ff <= '0;
         width_ff    <= WIDTH_W'(640);
         height_ff   <= HEIGHT_W'(480);
         lanes_ff    <= LANES_W'(3);
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_COEF_TOP:    coef_top_ff <= csr_pwdata[ROWREG_W-1:0];
            CSR_COEF_MIDDLE: coef_mid_ff <= csr_pwdata[ROWREG_W-1:0];
            CSR_COEF_BOTTOM: coef_bot_ff <= csr_pwdata[ROWREG_W-1:0];
            CSR_WIDTH:       width_ff    <= csr_pwdata[WIDTH_W-1:0];
            CSR_HEIGHT:      height_ff   <= csr_pwdata[HEIGHT_W-1:0];
            CSR_LANES:       lanes_ff    <= csr_pwdata[LANES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_COEF_TOP:    csr_prdata = CSR_DW'(coef_top_ff);
         CSR_COEF_MIDDLE: csr_prdata = CSR_DW'(coef_mid_ff);
         CSR_COEF_BOTTOM: csr_prdata = CSR_DW'(coef_bot_ff);
         CSR_WIDTH:       csr_prdata = CSR_DW'(width_ff);
         CSR_HEIGHT:      csr_prdata = CSR_DW'(height_ff);
         CSR_LANES:       csr_prdata = CSR_DW'(lanes_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- effective geometry ----------------
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
      if (lanes_ff == '0) begin
         lanes_eff = LANES_W'(1);
      end else if (lanes_ff > LANES_W'(LANES)) begin
         lanes_eff = LANES_W'(LANES);
      end else begin
         lanes_eff = lanes_ff;
      end
   end

   assign w_last = COL_W'(w_eff - WIDTH_W'(1));

   // ---------------- position and window bookkeeping ----------------
   assign samples = {req_sample_ch3, req_sample_ch2, req_sample_ch1, req_sample_ch0};

   always_comb begin
      wrap_pre = {1'b0, in_column_ff} >= w_eff;
      col_pre  = wrap_pre ? '0 : in_column_ff;
      row_pre  = wrap_pre ? in_row_ff + ROW_W'(1) : in_row_ff;
      drain    = row_pre >= ROW_W'(h_eff);
      accept   = req_valid && req_ready;
      process  = accept && !(req_kind && !drain);

      for (int k = 0; k < LANES; k++) begin
         pixel[k] = (!drain && (LANES_W'(k) < lanes_eff)) ? samples[k] : 8'd0;
      end

      col_nz = col_pre != '0;
      if (col_nz) begin
         win_valid = row_pre >= ROW_W'(1);
         crow      = row_pre - ROW_W'(1);
         ccol      = col_pre - COL_W'(1);
      end else begin
         win_valid = row_pre >= ROW_W'(2);
         crow      = row_pre - ROW_W'(2);
         ccol      = w_last;
      end
      emit      = win_valid && (crow < ROW_W'(h_eff));
      pad_top   = crow == '0;
      pad_bot   = crow == ROW_W'(h_eff - HEIGHT_W'(1));
      pad_left  = ccol == '0;
      pad_right = ccol == w_last;
      last      = emit && pad_bot && pad_right;

      col_inc   = WIDTH_W'(col_pre) + WIDTH_W'(1);
      wrap_post = col_inc >= w_eff;
      col_post  = wrap_post ? '0 : col_inc[COL_W-1:0];
      row_post  = wrap_post ? row_pre + ROW_W'(1) : row_pre;
      if (last || (row_pre >= ROW_W'(h_eff) + ROW_W'(1))) begin
         col_post = '0;
         row_post = '0;
      end

      if (process) begin
         in_column_in = col_post;
         in_row_in    = row_post;
      end else if (accept) begin
         in_column_in = col_pre;
         in_row_in    = row_pre;
      end else begin
         in_column_in = in_column_ff;
         in_row_in    = in_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
      end else begin
         in_column_ff <= in_column_in;
         in_row_ff    <= in_row_in;
      end
   end

   // ---------------- pipeline control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p1_emit_ff  <= 1'b0;
         p2_emit_ff  <= 1'b0;
         p3_emit_ff  <= 1'b0;
         p4_emit_ff  <= 1'b0;
      end else begin
         p1_valid_ff <= process;
         p1_emit_ff  <= process && emit;
         p2_emit_ff  <= p1_emit_ff;
         p3_emit_ff  <= p2_emit_ff;
         p4_emit_ff  <= p3_emit_ff;
      end
   end

   // Payload side of the pipeline
   always_ff @(posedge clock) begin
      p1_pixel_ff <= pixel;
      p1_last_ff  <= last;
      p1_top_ff   <= pad_top;
      p1_bot_ff   <= pad_bot;
      p1_left_ff  <= pad_left;
      p1_right_ff <= pad_right;
      p2_last_ff  <= p1_last_ff;
      p2_top_ff   <= p1_top_ff;
      p2_bot_ff   <= p1_bot_ff;
      p2_left_ff  <= p1_left_ff;
      p2_right_ff <= p1_right_ff;
      p3_last_ff  <= p2_last_ff;
      p4_last_ff  <= p3_last_ff;
   end

   // ---------------- line stores ----------------
   imconv3_line_buf u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (process),
      .addr     (col_pre),
      .wr_pixel (pixel),
      .up1      (up1),
      .up2      (up2)
   );

   // ---------------- window cells ----------------
   assign col_link[3] = {p1_pixel_ff, up1, up2};

   for (genvar c = 0; c < 3; c++) begin : g_cell
      assign ctrl[c].shift    = p1_valid_ff;
      assign ctrl[c].kill_top = p2_top_ff;
      assign ctrl[c].kill_bot = p2_bot_ff;
      assign ctrl[c].kill_col = (c == 0) ? p2_left_ff : (c == 2) ? p2_right_ff : 1'b0;
      assign coef[c] = {coef_bot_ff[COEF_W*c +: COEF_W],
                        coef_mid_ff[COEF_W*c +: COEF_W],
                        coef_top_ff[COEF_W*c +: COEF_W]};

      imconv3_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl[c]),
         .col_in  (col_link[c+1]),
         .coef    (coef[c]),
         .col_out (col_link[c]),
         .colsum  (colsum[c])
      );
   end

   // ---------------- final sum, scale and saturate ----------------
   always_comb begin
      logic signed [SUM_W-1:0]         sum;
      logic signed [SUM_W-FRAC_W-1:0]  q;
      for (int k = 0; k < LANES; k++) begin
         sum = $signed(colsum[0][k]) + $signed(colsum[1][k]) + $signed(colsum[2][k]);
         q   = sum[SUM_W-1:FRAC_W];
         if (LANES_W'(k) >= lanes_eff || q < 0) begin
            result.data[k] = 8'd0;
         end else if (q > 255) begin
            result.data[k] = 8'd255;
         end else begin
            result.data[k] = q[7:0];
         end
      end
      result.frame_end = p4_last_ff;
   end

   // ---------------- result queue ----------------
   assign push      = p4_emit_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign inflight  = (FIFO_CW+1)'(count_ff) + (FIFO_CW+1)'(p1_emit_ff)
                    + (FIFO_CW+1)'(p2_emit_ff) + (FIFO_CW+1)'(p3_emit_ff)
                    + (FIFO_CW+1)'(p4_emit_ff);
   assign req_ready = inflight < (FIFO_CW+1)'(FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         count_ff <= count_ff + FIFO_CW'(push) - FIFO_CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_filtered_ch0 = fifo_ff[rd_ptr_ff].data[0];
   assign rsp_filtered_ch1 = fifo_ff[rd_ptr_ff].data[1];
   assign rsp_filtered_ch2 = fifo_ff[rd_ptr_ff].data[2];
   assign rsp_filtered_ch3 = fifo_ff[rd_ptr_ff].data[3];
   assign rsp_frame_end    = fifo_ff[rd_ptr_ff].frame_end;

`ifndef SYNTH
   // Queue plus beats in flight never exceed the queue depth
   a_credit: assert property (@(posedge clock) disable iff (reset)
      inflight <= (FIFO_CW+1)'(FIFO_DEPTH))
      else $error("result queue credit exceeded");

   // A full queue is never written without a read
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff < FIFO_CW'(FIFO_DEPTH)))
      else $error("result queue overflow");

   // The last output of a frame returns the position to the frame start
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (process && last) |=> (in_column_ff == '0 && in_row_ff == '0))
      else $error("position not reset after frame end");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x3 zero-padded convolution block.
// Frames of random size, kernel and lane count are streamed through the
// block. A software copy of the filter predicts each output pixel,
// and the monitor compares every result beat with it, field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import imconv3_pkg::*;

   typedef struct packed {
      logic       kind;
      logic [3:0][7:0] smp;
   } pixel_beat_type;

   typedef struct packed {
      logic [3:0][7:0] filt;
      logic            fend;
   } filtered_pixel_type;

   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready, req_kind = 1'b0;
   logic [7:0] req_sample_ch0 = '0, req_sample_ch1 = '0, req_sample_ch2 = '0,
               req_sample_ch3 = '0;
   logic rsp_valid, rsp_ready = 1'b0, rsp_frame_end;
   logic [7:0] rsp_filtered_ch0, rsp_filtered_ch1, rsp_filtered_ch2, rsp_filtered_ch3;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0, csr_pready;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0, csr_prdata;

   image_convolution_3x3 dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Filter state mirrored by the predictor
   logic [47:0] kern_top = '0, kern_mid = 48'h000001000000, kern_bot = '0;
   logic [10:0] cfg_width = 11'd640;
   logic [15:0] cfg_height = 16'd480;
   logic [2:0]  cfg_lanes = 3'd3;
   logic [31:0] row_prev [MAX_WIDTH];
   logic [31:0] row_prev2 [MAX_WIDTH];
   logic [31:0] win [9];
   int unsigned pos_col = 0, pos_row = 0;

   pixel_beat_type     pending_pixels[$];
   filtered_pixel_type expected_pixels[$];
   int unsigned cyc = 0, errors = 0, beats_in = 0, beats_out = 0, frames_sent = 0;

   initial begin
      foreach (row_prev[i]) begin
         row_prev[i] = '0;
         row_prev2[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
   end

   function automatic longint kern_tap(int r, int c);
      logic [47:0] rowv;
      rowv = (r == 0) ? kern_top : (r == 1) ? kern_mid : kern_bot;
      return longint'($signed(rowv[16*c +: 16]));
   endfunction

   // Advance the mirrored filter by one accepted beat
   task automatic convolve_beat(pixel_beat_type b);
      int unsigned w, h, ln, col, arow, crow, ccol;
      logic [31:0] pix, up1, up2;
      logic valid_w, emit, last;
      longint acc, q;
      filtered_pixel_type res;
      w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      h = (cfg_height == 0) ? 1 : cfg_height;
      ln = (cfg_lanes == 0) ? 1 : (cfg_lanes > 4) ? 4 : cfg_lanes;
      pix = '0;
      crow = 0;
      ccol = 0;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
      end
      // drop flush ticks inside the frame
      if (b.kind && pos_row < h) return;
      if (pos_row < h)
         for (int k = 0; k < ln; k++) pix[8*k +: 8] = b.smp[k];
      col = pos_col;
      arow = pos_row;
      up2 = row_prev2[col];
      up1 = row_prev[col];
      for (int r = 0; r < 3; r++) begin
         win[3*r] = win[3*r+1];
         win[3*r+1] = win[3*r+2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = pix;
      row_prev2[col] = up1;
      row_prev[col] = pix;
      if (col >= 1) begin
         valid_w = arow >= 1;
         if (valid_w) begin
            crow = arow - 1;
            ccol = col - 1;
         end
      end else begin
         valid_w = arow >= 2;
         if (valid_w) begin
            crow = arow - 2;
            ccol = w - 1;
         end
      end
      emit = valid_w && crow < h;
      last = emit && crow == h - 1 && ccol == w - 1;
      pos_col++;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
      end
      if (last || arow >= h + 1) begin
         pos_col = 0;
         pos_row = 0;
      end
      if (!emit) return;
      // sum masked taps per lane, floor-shift, saturate
      for (int k = 0; k < 4; k++) begin
         acc = 0;
         q = 0;
         if (k < ln) begin
            for (int r = 0; r < 3; r++)
               for (int c = 0; c < 3; c++)
                  if (!(r == 0 && crow == 0) && !(r == 2 && crow == h - 1) &&
                      !(c == 0 && ccol == 0) && !(c == 2 && ccol == w - 1))
                     acc += kern_tap(r, c) * longint'(win[3*r+c][8*k +: 8]);
            q = acc >>> 8;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
         end
         res.filt[k] = q[7:0];
      end
      res.fend = last;
      expected_pixels.push_back(res);
   endtask

   // Calm window: no idling on either side
   wire calm = (cyc % 9000) < 2000;

   // Driver: hold payload until accepted, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_pixels.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
            req_valid <= 1'b1;
            req_kind <= pending_pixels[0].kind;
            req_sample_ch0 <= pending_pixels[0].smp[0];
            req_sample_ch1 <= pending_pixels[0].smp[1];
            req_sample_ch2 <= pending_pixels[0].smp[2];
            req_sample_ch3 <= pending_pixels[0].smp[3];
            void'(pending_pixels.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on input beats, check result beats
   always @(posedge clock) begin
      filtered_pixel_type exp_px;
      cyc <= cyc + 1;
      if (!reset) begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
         if (req_valid && req_ready) begin
            beats_in++;
            convolve_beat({req_kind, req_sample_ch3, req_sample_ch2,
                           req_sample_ch1, req_sample_ch0});
         end
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (expected_pixels.size() == 0) begin
               errors++;
               $error("unexpected result beat");
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_filtered_ch0 !== exp_px.filt[0]) begin
                  errors++;
                  $error("filtered_ch0 exp %0d got %0d", exp_px.filt[0], rsp_filtered_ch0);
               end
               if (rsp_filtered_ch1 !== exp_px.filt[1]) begin
                  errors++;
                  $error("filtered_ch1 exp %0d got %0d", exp_px.filt[1], rsp_filtered_ch1);
               end
               if (rsp_filtered_ch2 !== exp_px.filt[2]) begin
                  errors++;
                  $error("filtered_ch2 exp %0d got %0d", exp_px.filt[2], rsp_filtered_ch2);
               end
               if (rsp_filtered_ch3 !== exp_px.filt[3]) begin
                  errors++;
                  $error("filtered_ch3 exp %0d got %0d", exp_px.filt[3], rsp_filtered_ch3);
               end
               if (rsp_frame_end !== exp_px.fend) begin
                  errors++;
                  $error("frame_end exp %0d got %0d", exp_px.fend, rsp_frame_end);
               end
            end
         end
      end
      if (cyc > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_pixels.size());
         $display("image_convolution_3x3: mismatch");
         $finish;
      end
   end

   // Register write: setup then access cycle
   task automatic csr_write(csr_index_type idx, logic [63:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(8 * idx);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_COEF_TOP:    kern_top = val[47:0];
         CSR_COEF_MIDDLE: kern_mid = val[47:0];
         CSR_COEF_BOTTOM: kern_bot = val[47:0];
         CSR_WIDTH:       cfg_width = val[10:0];
         CSR_HEIGHT:      cfg_height = val[15:0];
         CSR_LANES:       cfg_lanes = val[2:0];
         default: ;
      endcase
   endtask

   // Let the block drain before touching registers
   task automatic wait_idle();
      while (pending_pixels.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   function automatic logic [47:0] rand_kernel(bit tame);
      logic [47:0] v;
      v = {$urandom, $urandom};
      if (tame)
         for (int c = 0; c < 3; c++) v[16*c +: 16] = 16'($urandom_range(0, 127)) - 16'd40;
      return v;
   endfunction

   // Queue one frame with stray flush ticks inside and a mixed drain tail
   task automatic push_frame(int unsigned pattern);
      int unsigned w, h;
      pixel_beat_type b;
      w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      h = (cfg_height == 0) ? 1 : cfg_height;
      for (int unsigned i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            b = {1'b1, $urandom};
            pending_pixels.push_back(b);
         end
         case (pattern)
            0: b = {1'b0, 32'h0};
            1: b = {1'b0, 32'hFFFF_FFFF};
            default: b = {1'b0, $urandom};
         endcase
         pending_pixels.push_back(b);
      end
      for (int unsigned i = 0; i <= w; i++) begin
         b = {1'($urandom_range(0, 1)), $urandom};
         pending_pixels.push_back(b);
      end
      frames_sent++;
   endtask

   initial begin
      int unsigned queued;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: identity kernel, then extreme kernels, with small frames and extreme samples
      csr_write(CSR_WIDTH, 64'd3);
      csr_write(CSR_HEIGHT, 64'd0);
      csr_write(CSR_LANES, 64'd0);
      push_frame(1);
      wait_idle();
      csr_write(CSR_HEIGHT, 64'd3);
      csr_write(CSR_LANES, 64'd7);
      csr_write(CSR_COEF_TOP, 64'h7FFF_7FFF_7FFF);
      csr_write(CSR_COEF_MIDDLE, 64'h7FFF_7FFF_7FFF);
      csr_write(CSR_COEF_BOTTOM, 64'h7FFF_7FFF_7FFF);
      push_frame(1);
      push_frame(0);
      wait_idle();
      csr_write(CSR_WIDTH, 64'd0);
      csr_write(CSR_COEF_TOP, 64'h8000_8000_8000);
      csr_write(CSR_COEF_MIDDLE, 64'h8000_8000_8000);
      csr_write(CSR_COEF_BOTTOM, 64'h8000_8000_8000);
      push_frame(2);
      wait_idle();

      // random phases, one wide single-row frame among them
      queued = 0;
      for (int ph = 0; queued < 1400; ph++) begin
         csr_write(CSR_COEF_TOP, {16'h0, rand_kernel($urandom_range(0, 2) != 0)});
         csr_write(CSR_COEF_MIDDLE, {16'h0, rand_kernel($urandom_range(0, 2) != 0)});
         csr_write(CSR_COEF_BOTTOM, {16'h0, rand_kernel($urandom_range(0, 2) != 0)});
         csr_write(CSR_LANES, 64'($urandom_range(0, 7)));
         if (ph == 5) begin
            csr_write(CSR_WIDTH, 64'd600);
            csr_write(CSR_HEIGHT, 64'd1);
         end else begin
            csr_write(CSR_WIDTH, 64'($urandom_range(0, 12)));
            csr_write(CSR_HEIGHT, 64'($urandom_range(0, 6)));
         end
         repeat ((ph == 5) ? 1 : $urandom_range(1, 2)) begin
            push_frame(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2);
         end
         queued += pending_pixels.size();
         wait_idle();
      end

      // tallest frame setting: run its opening rows only
      csr_write(CSR_WIDTH, 64'd1);
      csr_write(CSR_HEIGHT, 64'd65535);
      repeat (40) pending_pixels.push_back({1'b0, $urandom});
      while (pending_pixels.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);

      $display("covered %0d frames, %0d input beats, %0d checked output pixels",
               frames_sent, beats_in, beats_out);
      $display("with a wide row, padded borders, lane limits and saturation");
      if (errors == 0 && expected_pixels.size() == 0)
         $display("image_convolution_3x3: match");
      else
         $display("image_convolution_3x3: mismatch");
      $finish;
   end

endmodule

### files.f
design/imconv3_pkg.sv
design/imconv3_line_buf.sv
design/imconv3_cell.sv
design/image_convolution_3x3.sv
bench/tb_top.sv
